FILE: sv/block_map_allocator_macros.svh
// ----------------------------------------------------------------------------
// Block map allocator assertion macros
// Concurrent assertion wrappers used by the block map allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MAP_ALLOCATOR_MACROS_SVH
`define BLOCK_MAP_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked outside reset only.
`define BMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMA_ASSERT(lbl, prop, msg)
`define BMA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: sv/bma_pkg.sv
// ----------------------------------------------------------------------------
// Block map allocator package
// Pool geometry, field widths, status and operation codes, map command type.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int TABLE_BLOCKS = 256;
    localparam int BLOCK_BYTES  = 32;
    localparam int POOL_BYTES   = TABLE_BLOCKS * BLOCK_BYTES;

    localparam int ADDR_W       = $clog2(TABLE_BLOCKS);
    localparam int CNT_W        = $clog2(TABLE_BLOCKS + 1);

    localparam int BYTES_W      = 16;
    localparam int OFFSET_W     = 13;
    localparam int USED_W       = 9;
    localparam int PCT_W        = 7;
    localparam int PCT_SCALE    = 100;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // One access to the block map per cycle.
    typedef struct packed {
        logic              set_en;
        logic              clr_en;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  len;
    } map_cmd_t;

endpackage

FILE: sv/bma_block_map.sv
// ----------------------------------------------------------------------------
// Block map storage
// Run length memory plus one in-use flag per block, cleared at reset.
// ----------------------------------------------------------------------------
module bma_block_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bma_pkg::map_cmd_t         cmd,
    output logic                      cur_used,
    output logic [bma_pkg::CNT_W-1:0] rd_len
);
    import bma_pkg::*;

    logic [CNT_W-1:0]        len_mem_reg [TABLE_BLOCKS];
    logic [TABLE_BLOCKS-1:0] used_reg;
    logic [CNT_W-1:0]        rd_len_reg;
    logic                    rd_used_reg;

    // The flag says whether the entry is nonzero; the memory is only
    // meaningful where the flag is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_en)
            begin
                used_reg[cmd.addr] <= 1'b1;
            end
            else if (cmd.clr_en)
            begin
                used_reg[cmd.addr] <= 1'b0;
            end
            rd_used_reg <= used_reg[cmd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_en)
        begin
            len_mem_reg[cmd.addr] <= cmd.len;
        end
        rd_len_reg <= len_mem_reg[cmd.addr];
    end

    assign cur_used = used_reg[cmd.addr];
    assign rd_len   = rd_used_reg ? rd_len_reg : '0;

endmodule

FILE: sv/block_map_allocator.sv
// ----------------------------------------------------------------------------
// Block map allocator
// First-fit, top-down block allocator over a run length map.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer happens on a rising edge with start high and busy low;
// operation selects allocate or free, with request_bytes or release_offset.
// Exactly one result follows, shown for one cycle with done high: status,
// granted_offset, used_blocks and usage_percent. The receiver cannot stall,
// so the result must be taken in that cycle.
// Flow: a rejected command (zero size, oversized, offset out of range)
// goes straight from idle to the report state. An allocate scans one map
// entry per cycle through the single map port from the top block down,
// then writes one entry per cycle of the run and reports. A free reads the
// stored length through the FREE_RD and FREE_LEN states and clears one
// entry per cycle. Busy stays high for the whole command and drops in the
// cycle done is shown, so the next command can be transferred while a
// result is on the ports.
// Reset clears every in-use flag and the used count at once, so the block
// accepts commands as soon as reset is released.
// ----------------------------------------------------------------------------
`include "block_map_allocator_macros.svh"

module block_map_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [bma_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [bma_pkg::BYTES_W-1:0]  release_offset,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [bma_pkg::OFFSET_W-1:0] granted_offset,
    output logic [bma_pkg::USED_W-1:0]   used_blocks,
    output logic [bma_pkg::PCT_W-1:0]    usage_percent
);
    import bma_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_LEN,
        ST_FREE_CLR,
        ST_REPORT
    } state_t;

    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(TABLE_BLOCKS - 1);

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]     need_reg, need_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [1:0]           status_reg, status_next;
    logic [OFFSET_W-1:0]  granted_reg, granted_next;
    logic [USED_W-1:0]    res_used_reg, res_used_next;
    logic                 done_reg, done_next;

    map_cmd_t             map_cmd;
    logic                 map_used;
    logic [CNT_W-1:0]     map_len;

    logic [BYTES_W:0]     need_wide;
    logic [BYTES_W-1:0]   idx_wide;
    logic [31:0]          granted_wide;
    logic [CNT_W-1:0]     run_inc;
    logic [16:0]          pct_wide;
    logic                 fail_shown;

    bma_block_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (map_cmd),
        .cur_used (map_used),
        .rd_len   (map_len)
    );

    // Block count of the request, rounded up.
    assign need_wide    = (BYTES_W+1)'(({1'b0, request_bytes}
                          + (BYTES_W+1)'(BLOCK_BYTES - 1)) / BLOCK_BYTES);
    assign idx_wide     = BYTES_W'(release_offset / BLOCK_BYTES);
    assign granted_wide = 32'(addr_reg) * 32'(BLOCK_BYTES);
    assign run_inc      = map_used ? '0 : run_reg + 1'b1;

    always_comb
    begin
        map_cmd        = '0;
        map_cmd.addr   = addr_reg;
        map_cmd.len    = need_reg;
        map_cmd.set_en = (state_reg == ST_MARK);
        map_cmd.clr_en = (state_reg == ST_FREE_CLR);
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        need_next     = need_reg;
        run_next      = run_reg;
        cnt_next      = cnt_reg;
        used_next     = used_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        res_used_next = res_used_reg;
        done_next     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    granted_next = '0;
                    status_next  = STATUS_OK;
                    if (operation == OP_ALLOC)
                    begin
                        if (request_bytes == '0 ||
                            need_wide > (BYTES_W+1)'(TABLE_BLOCKS))
                        begin
                            status_next = STATUS_NOFIT;
                            state_next  = ST_REPORT;
                        end
                        else
                        begin
                            need_next  = need_wide[CNT_W-1:0];
                            addr_next  = ADDR_MAX;
                            run_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (32'(release_offset) >= 32'(POOL_BYTES))
                    begin
                        status_next = STATUS_RANGE;
                        state_next  = ST_REPORT;
                    end
                    else
                    begin
                        addr_next  = idx_wide[ADDR_W-1:0];
                        state_next = ST_FREE_RD;
                    end
                end
            end

            ST_SCAN:
            begin
                run_next = run_inc;
                if (run_inc == need_reg)
                begin
                    // The run covers this block and the ones just above it.
                    granted_next = granted_wide[OFFSET_W-1:0];
                    used_next    = used_reg + need_reg;
                    cnt_next     = need_reg;
                    state_next   = ST_MARK;
                end
                else if (addr_reg == '0)
                begin
                    status_next = STATUS_NOFIT;
                    state_next  = ST_REPORT;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end

            ST_MARK:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            ST_FREE_RD:
            begin
                state_next = ST_FREE_LEN;
            end

            ST_FREE_LEN:
            begin
                cnt_next   = map_len;
                state_next = (map_len == '0) ? ST_REPORT : ST_FREE_CLR;
            end

            ST_FREE_CLR:
            begin
                if (map_used)
                begin
                    used_next = used_reg - 1'b1;
                end
                // Clearing stops at the last block of the table.
                if (cnt_reg == CNT_W'(1) || addr_reg == ADDR_MAX)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            ST_REPORT:
            begin
                res_used_next = USED_W'(used_reg);
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            done_reg     <= 1'b0;
            addr_reg     <= '0;
            need_reg     <= '0;
            run_reg      <= '0;
            cnt_reg      <= '0;
            status_reg   <= STATUS_OK;
            granted_reg  <= '0;
            res_used_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            done_reg     <= done_next;
            addr_reg     <= addr_next;
            need_reg     <= need_next;
            run_reg      <= run_next;
            cnt_reg      <= cnt_next;
            status_reg   <= status_next;
            granted_reg  <= granted_next;
            res_used_reg <= res_used_next;
        end
    end

    assign pct_wide       = 17'(17'(res_used_reg) * 17'(PCT_SCALE) / TABLE_BLOCKS);

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign used_blocks    = res_used_reg;
    assign usage_percent  = pct_wide[PCT_W-1:0];

    assign fail_shown     = done_reg && (status_reg != STATUS_OK);

    `BMA_ASSERT_ALWAYS(a_done_not_busy, done_reg |-> !busy, "result shown while busy")
    `BMA_ASSERT_ALWAYS(a_used_bound, used_reg <= CNT_W'(TABLE_BLOCKS), "used count overflow")
    `BMA_ASSERT(a_start_busy, (start && !busy) |=> busy, "command transfer did not start work")
    `BMA_ASSERT(a_fail_no_offset, fail_shown |-> granted_reg == '0, "offset on failed result")
    `BMA_ASSERT(a_mark_free, (state_reg == ST_MARK) |-> !map_used, "marking a block in use")

endmodule
